### hdl/mcspg_pkg.sv
// Shared types and constants for the multi-channel step pulse generator.
// Used by every module in hdl/; depends on nothing.
package mcspg_pkg;

    localparam int FUNC_W        = 3;
    localparam int CHAN_W        = 3;
    localparam int FREQ_W        = 24;
    localparam int PULSES_W      = 31;
    localparam int PIN_W         = 6;
    localparam int CLOCK_RATE_W  = 28;

    localparam int CHANNELS_DEF    = 6;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int CLOCK_RESET_INT = 40000000;
    localparam int RESET_FREQUENCY = 5;
    // half period loaded at reset: (clock / f) / 2 - 1
    localparam int RESET_HALF_INT  = (CLOCK_RESET_INT / RESET_FREQUENCY) / 2 - 1;
    localparam logic [CLOCK_RATE_W-1:0] CLOCK_RESET = CLOCK_RATE_W'(CLOCK_RESET_INT);

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK  = 3'd0,
        FN_MOVE  = 3'd1,
        FN_FREE  = 3'd2,
        FN_STOP  = 3'd3,
        FN_SETF  = 3'd4,
        FN_SETD  = 3'd5
    } func_t;

    // per-channel timer outcome from the shared tick unit
    typedef struct packed {
        logic toggle;
        logic stop;
    } chan_ctl_t;

endpackage

### hdl/mcspg_div.sv
// Restoring divider, one quotient bit per cycle: clock_rate / frequency.
// Depends on mcspg_pkg for field widths.
module mcspg_div
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [mcspg_pkg::CLOCK_RATE_W-1:0]   dividend,
    input  logic [mcspg_pkg::FREQ_W-1:0]         divisor,
    output logic                                 done,
    output logic [mcspg_pkg::CLOCK_RATE_W-1:0]   quotient
);

    localparam int DW = mcspg_pkg::CLOCK_RATE_W;
    localparam int VW = mcspg_pkg::FREQ_W;
    localparam int CW = $clog2(DW);

    logic          active_reg, active_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] dvd_reg, dvd_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] dsr_reg, dsr_next;
    logic [VW-1:0] rem_reg, rem_next;

    logic [VW:0]   rem_sh;
    logic [VW+1:0] diff;
    logic          ge;

    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[DW-1]};
        diff   = {1'b0, rem_sh} - {2'b00, dsr_reg};
        ge     = ~diff[VW+1];

        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        dvd_next    = dvd_reg;
        quo_next    = quo_reg;
        dsr_next    = dsr_reg;
        rem_next    = rem_reg;

        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
            dvd_next    = dividend;
            dsr_next    = divisor;
            rem_next    = '0;
        end
        else if (active_reg)
        begin
            // remainder stays below the divisor, so VW bits hold it
            rem_next = ge ? diff[VW-1:0] : rem_sh[VW-1:0];
            quo_next = {quo_reg[DW-2:0], ge};
            dvd_next = {dvd_reg[DW-2:0], 1'b0};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(DW - 1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hdl/mcspg_tick_unit.sv
// Shared timer step for one channel: countdown, reload, toggle, pulse count.
// Depends on mcspg_pkg for chan_ctl_t.
module mcspg_tick_unit
#(
    parameter int COUNT_WIDTH = mcspg_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                   run,
    input  logic                   free,
    input  logic [COUNT_WIDTH-1:0] countdown,
    input  logic [COUNT_WIDTH-1:0] half_period,
    input  logic [COUNT_WIDTH-1:0] pulses_left,
    output logic [COUNT_WIDTH-1:0] countdown_new,
    output logic [COUNT_WIDTH-1:0] pulses_new,
    output mcspg_pkg::chan_ctl_t   ctl
);

    always_comb
    begin
        countdown_new = countdown;
        pulses_new    = pulses_left;
        ctl           = '0;
        if (run)
        begin
            if (countdown != '0)
            begin
                countdown_new = countdown - COUNT_WIDTH'(1);
            end
            else
            begin
                countdown_new = half_period;
                ctl.toggle    = 1'b1;
                if (!free)
                begin
                    if (pulses_left != '0)
                    begin
                        pulses_new = pulses_left - COUNT_WIDTH'(1);
                    end
                    ctl.stop = (pulses_left <= COUNT_WIDTH'(1));
                end
            end
        end
    end

endmodule

### hdl/multi_channel_step_pulse_generator.sv
// Simple requests go from accept straight to S_DONE; a tick first takes one shared
// timer step per channel in S_TICK; move / set frequency wait in S_DIV for the
// bit-serial divider, then load the channel. One request in flight; the next is
// accepted once the result is registered in S_DONE, and a result left waiting
// holds the sequencer in S_DONE.
// Reset (rst_n, async, low): all channels stopped, step and direction state low
// (the pin output registers are not reset), half period 3999999, clock_rate 40000000.
// Top level: sequencer, channel state, output register; uses mcspg_pkg,
// mcspg_div and mcspg_tick_unit.
module multi_channel_step_pulse_generator
#(
    parameter int CHANNELS    = mcspg_pkg::CHANNELS_DEF,
    parameter int COUNT_WIDTH = mcspg_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               clock_rate_we,
    input  logic [mcspg_pkg::CLOCK_RATE_W-1:0] clock_rate_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [mcspg_pkg::FUNC_W-1:0]       func,
    input  logic [mcspg_pkg::CHAN_W-1:0]       channel,
    input  logic [mcspg_pkg::FREQ_W-1:0]       frequency,
    input  logic                               direction,
    input  logic [mcspg_pkg::PULSES_W-1:0]     pulses,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [mcspg_pkg::PIN_W-1:0]        step_pins,
    output logic [mcspg_pkg::PIN_W-1:0]        dir_pins,
    output logic [mcspg_pkg::PIN_W-1:0]        running_mask,
    output logic                               bad_frequency
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PIN_W = mcspg_pkg::PIN_W;
    localparam int QW    = mcspg_pkg::CLOCK_RATE_W;
    localparam logic [COUNT_WIDTH-1:0] RESET_HALF = COUNT_WIDTH'(mcspg_pkg::RESET_HALF_INT);
    localparam logic [mcspg_pkg::PULSES_W+1:0] COUNT_MAX =
        (mcspg_pkg::PULSES_W+2)'({COUNT_WIDTH{1'b1}});

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_DIV,
        S_DONE
    } state_t;

    typedef logic [COUNT_WIDTH-1:0] cnt_arr_t [CHANNELS];

    state_t                 state_reg, state_next;
    logic [mcspg_pkg::CLOCK_RATE_W-1:0] clock_rate_reg, clock_rate_next;
    cnt_arr_t               half_reg, half_next;
    cnt_arr_t               cdown_reg, cdown_next;
    cnt_arr_t               hpl_reg, hpl_next;
    logic [CHANNELS-1:0]    run_reg, run_next;
    logic [CHANNELS-1:0]    free_reg, free_next;
    logic [CHANNELS-1:0]    step_reg, step_next;
    logic [CHANNELS-1:0]    dir_reg, dir_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   bad_reg, bad_next;
    logic                   cmd_move_reg, cmd_move_next;
    logic                   cmd_dir_reg, cmd_dir_next;
    logic [COUNT_WIDTH-1:0] cmd_twice_reg, cmd_twice_next;
    logic                   out_valid_reg, out_valid_next;
    logic [PIN_W-1:0]       step_out_reg, step_out_next;
    logic [PIN_W-1:0]       dir_out_reg, dir_out_next;
    logic [PIN_W-1:0]       run_out_reg, run_out_next;
    logic                   bad_out_reg, bad_out_next;

    logic                   accept;
    mcspg_pkg::func_t       fn;
    logic                   ch_ok;
    logic [IDX_W-1:0]       cur;
    logic [CHANNELS-1:0]    cur_bit;
    logic                   div_start;
    logic                   div_done;
    logic [QW-1:0]          quotient;
    logic [QW-2:0]          half_q;
    logic [COUNT_WIDTH-1:0] load_val;
    logic [mcspg_pkg::PULSES_W+1:0] twice;
    logic [COUNT_WIDTH-1:0] tu_cdown;
    logic [COUNT_WIDTH-1:0] tu_pulses;
    mcspg_pkg::chan_ctl_t   tu_ctl;

    function automatic logic [PIN_W-1:0] pin_view(input logic [CHANNELS-1:0] v);
        logic [CHANNELS+PIN_W-1:0] ext;
        ext      = {PIN_W'(0), v};
        pin_view = ext[PIN_W-1:0];
    endfunction

    assign accept = in_valid && in_ready;
    assign fn     = mcspg_pkg::func_t'(func);
    assign ch_ok  = (32'(channel) < CHANNELS);
    assign cur    = (state_reg == S_TICK) ? idx_reg : idx_reg;
    assign cur_bit = CHANNELS'(1) << cur;

    assign div_start = (state_reg == S_IDLE) && accept && ch_ok && (frequency != '0)
                       && ((fn == mcspg_pkg::FN_MOVE) || (fn == mcspg_pkg::FN_SETF));

    mcspg_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (clock_rate_reg),
        .divisor  (frequency),
        .done     (div_done),
        .quotient (quotient)
    );

    mcspg_tick_unit #(.COUNT_WIDTH(COUNT_WIDTH)) u_tick
    (
        .run           (run_reg[cur]),
        .free          (free_reg[cur]),
        .countdown     (cdown_reg[cur]),
        .half_period   (half_reg[cur]),
        .pulses_left   (hpl_reg[cur]),
        .countdown_new (tu_cdown),
        .pulses_new    (tu_pulses),
        .ctl           (tu_ctl)
    );

    // half = (clock / f) / 2, loaded as half - 1, floor at zero
    assign half_q   = quotient[QW-1:1];
    assign load_val = (half_q == '0) ? '0 : COUNT_WIDTH'(32'(half_q) - 32'd1);
    assign twice    = {1'b0, pulses, 1'b0};

    always_comb
    begin
        state_next      = state_reg;
        clock_rate_next = clock_rate_reg;
        half_next       = half_reg;
        cdown_next      = cdown_reg;
        hpl_next        = hpl_reg;
        run_next        = run_reg;
        free_next       = free_reg;
        step_next       = step_reg;
        dir_next        = dir_reg;
        idx_next        = idx_reg;
        bad_next        = bad_reg;
        cmd_move_next   = cmd_move_reg;
        cmd_dir_next    = cmd_dir_reg;
        cmd_twice_next  = cmd_twice_reg;
        out_valid_next  = out_valid_reg;
        step_out_next   = step_out_reg;
        dir_out_next    = dir_out_reg;
        run_out_next    = run_out_reg;
        bad_out_next    = bad_out_reg;

        if (clock_rate_we)
        begin
            clock_rate_next = clock_rate_wdata;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    bad_next       = 1'b0;
                    state_next     = S_DONE;
                    idx_next       = IDX_W'(channel);
                    cmd_move_next  = (fn == mcspg_pkg::FN_MOVE);
                    cmd_dir_next   = direction;
                    cmd_twice_next = (twice > COUNT_MAX) ? COUNT_MAX[COUNT_WIDTH-1:0]
                                                         : COUNT_WIDTH'(twice);
                    if (fn == mcspg_pkg::FN_TICK)
                    begin
                        idx_next   = '0;
                        state_next = S_TICK;
                    end
                    else if (ch_ok)
                    begin
                        case (fn)
                            mcspg_pkg::FN_MOVE,
                            mcspg_pkg::FN_SETF:
                            begin
                                if (frequency == '0)
                                begin
                                    bad_next = 1'b1;
                                end
                                else
                                begin
                                    state_next = S_DIV;
                                end
                            end
                            mcspg_pkg::FN_FREE:
                            begin
                                free_next = free_reg | (CHANNELS'(1) << IDX_W'(channel));
                                run_next  = run_reg | (CHANNELS'(1) << IDX_W'(channel));
                            end
                            mcspg_pkg::FN_STOP:
                            begin
                                run_next = run_reg & ~(CHANNELS'(1) << IDX_W'(channel));
                            end
                            mcspg_pkg::FN_SETD:
                            begin
                                dir_next[IDX_W'(channel)] = direction;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end

            S_TICK:
            begin
                cdown_next[cur] = tu_cdown;
                hpl_next[cur]   = tu_pulses;
                if (tu_ctl.toggle)
                begin
                    step_next = step_reg ^ cur_bit;
                end
                if (tu_ctl.stop)
                begin
                    run_next = run_reg & ~cur_bit;
                end
                if (idx_reg == IDX_W'(CHANNELS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    half_next[cur]  = load_val;
                    cdown_next[cur] = load_val;
                    if (cmd_move_reg)
                    begin
                        hpl_next[cur] = cmd_twice_reg;
                        free_next     = free_reg & ~cur_bit;
                        dir_next[cur] = cmd_dir_reg;
                        run_next[cur] = (cmd_twice_reg != '0);
                    end
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    step_out_next  = pin_view(step_reg);
                    dir_out_next   = pin_view(dir_reg);
                    run_out_next   = pin_view(run_reg);
                    bad_out_next   = bad_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            clock_rate_reg <= mcspg_pkg::CLOCK_RESET;
            for (int i = 0; i < CHANNELS; i++)
            begin
                half_reg[i]  <= RESET_HALF;
                cdown_reg[i] <= RESET_HALF;
                hpl_reg[i]   <= '0;
            end
            run_reg        <= '0;
            free_reg       <= '0;
            step_reg       <= '0;
            dir_reg        <= '0;
            idx_reg        <= '0;
            bad_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clock_rate_reg <= clock_rate_next;
            half_reg       <= half_next;
            cdown_reg      <= cdown_next;
            hpl_reg        <= hpl_next;
            run_reg        <= run_next;
            free_reg       <= free_next;
            step_reg       <= step_next;
            dir_reg        <= dir_next;
            idx_reg        <= idx_next;
            bad_reg        <= bad_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_move_reg  <= cmd_move_next;
        cmd_dir_reg   <= cmd_dir_next;
        cmd_twice_reg <= cmd_twice_next;
        step_out_reg  <= step_out_next;
        dir_out_reg   <= dir_out_next;
        run_out_reg   <= run_out_next;
        bad_out_reg   <= bad_out_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign step_pins     = step_out_reg;
    assign dir_pins      = dir_out_reg;
    assign running_mask  = run_out_reg;
    assign bad_frequency = bad_out_reg;

endmodule

### hdl/mcspg_checker.sv
// Port-level assertions for the step pulse generator, bound to the top level.
// Depends on mcspg_pkg for port widths.
module mcspg_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [mcspg_pkg::PIN_W-1:0] step_pins,
    input logic [mcspg_pkg::PIN_W-1:0] dir_pins,
    input logic [mcspg_pkg::PIN_W-1:0] running_mask,
    input logic                        bad_frequency
);

    // one request at a time: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready held after accepting a request");

    // a presented result carries known pin values
    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({step_pins, dir_pins, running_mask, bad_frequency}))
        else $error("result with unknown pin values");

    // a new result is only produced while input is blocked
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while idle");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(step_pins) && $stable(dir_pins)
            && $stable(running_mask) && $stable(bad_frequency))
        else $error("stalled result changed");

endmodule

bind multi_channel_step_pulse_generator mcspg_checker u_mcspg_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .step_pins     (step_pins),
    .dir_pins      (dir_pins),
    .running_mask  (running_mask),
    .bad_frequency (bad_frequency)
);
